[src/multiset_floor_extract_defines.svh]
// assertion macros for the multiset floor extract block
`ifndef MULTISET_FLOOR_EXTRACT_DEFINES_SVH
`define MULTISET_FLOOR_EXTRACT_DEFINES_SVH

`ifndef SYNTHESIS
`define MFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MFE_ASSERT(label, prop, msg)
`define MFE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[src/mfe_pkg.sv]
`timescale 1ns / 1ps

package mfe_pkg;

    localparam int CAPACITY = 1024;
    localparam int AMT_W    = 31;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GRP_SIZE = 32;
    localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [1:0] ST_MATCH    = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_INSERTED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef logic [AMT_W-1:0] t_amount;

    typedef struct packed {
        logic    req_type;
        t_amount amount;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        t_amount    found_value;
    } t_result;

    // broadcast to every cell
    typedef struct packed {
        logic cmp;   // latch compare flag against the incoming amount
        logic ins;   // insert update
        logic del;   // delete update
        logic pick;  // drive the matched value toward the reduction
    } t_cell_ctl;

endpackage

[src/multiset_floor_extract.sv]
`timescale 1ns / 1ps
// multiset_floor_extract: sorted multiset of up to CAPACITY 31-bit values
// request channel: i_req is taken at a rising edge where i_start is high and
//   o_busy is low. req_type insert adds amount; query removes and returns the
//   largest stored value not above amount.
// result channel: o_done is high for one cycle with o_result; the receiver
//   must take it then, there is no way to hold it off.
// the values sit in a row of cells kept in ascending order; every cell
//   compares against the request in the accept cycle, and in the next cycle
//   each cell loads from its left or right neighbor to open or close a gap.
// the block takes no new request while a cell update is under way; o_busy
//   is high for the single update cycle.
// output path: the matched value goes through a registered or-reduction over
//   groups of cells and then the output register, in step with o_done.
// results come out in request order, one per transaction.
// reset clears the fill count, so the store is empty right after reset;
//   cell contents are not cleared and cells above the count are ignored.

`include "multiset_floor_extract_defines.svh"

module multiset_floor_extract
    import mfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_req    i_req,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_result
);

    localparam int PAD_N = NUM_GRP * GRP_SIZE;

    logic             r_busy;
    t_req             r_req;
    logic [CNT_W-1:0] r_count;
    logic             r_v1;
    logic [1:0]       r_st1;
    logic             r_done;
    t_result          r_result;

    logic      w_accept;
    logic      w_full;
    logic      w_found;
    t_cell_ctl w_ctl;
    t_amount   w_found_or;

    logic [CAPACITY-1:0][AMT_W-1:0] w_value;
    logic [CAPACITY-1:0]            w_le;
    logic [CAPACITY-1:0]            w_valid;
    logic [PAD_N-1:0][AMT_W-1:0]    w_pick;
    logic [NUM_GRP-1:0][AMT_W-1:0]  w_part;

    assign w_accept = i_start && !r_busy;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_found  = w_le[0];

    always_comb begin
        w_ctl      = '0;
        w_ctl.cmp  = w_accept;
        w_ctl.ins  = r_busy && (r_req.req_type == REQ_INSERT) && !w_full;
        w_ctl.del  = r_busy && (r_req.req_type == REQ_QUERY) && w_found;
        w_ctl.pick = r_busy && (r_req.req_type == REQ_QUERY);
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_amount w_lo_value;
        logic    w_lo_le;
        t_amount w_hi_value;
        logic    w_hi_le;

        assign w_valid[i] = (CNT_W'(i) < r_count);

        if (i == 0) begin : g_first
            assign w_lo_value = '0;
            assign w_lo_le    = 1'b1;
        end else begin : g_mid_lo
            assign w_lo_value = w_value[i-1];
            assign w_lo_le    = w_le[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_hi_value = '0;
            assign w_hi_le    = 1'b0;
        end else begin : g_mid_hi
            assign w_hi_value = w_value[i+1];
            assign w_hi_le    = w_le[i+1];
        end

        mfe_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_valid    (w_valid[i]),
            .i_amount   (i_req.amount),
            .i_load     (r_req.amount),
            .i_lo_value (w_lo_value),
            .i_lo_le    (w_lo_le),
            .i_hi_value (w_hi_value),
            .i_hi_le    (w_hi_le),
            .o_value    (w_value[i]),
            .o_le       (w_le[i]),
            .o_pick     (w_pick[i])
        );
    end

    for (genvar i = CAPACITY; i < PAD_N; i++) begin : g_pad
        assign w_pick[i] = '0;
    end

    for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
        mfe_group u_group (
            .i_clk   (i_clk),
            .i_picks (w_pick[g*GRP_SIZE +: GRP_SIZE]),
            .o_any   (w_part[g])
        );
    end

    always_comb begin
        w_found_or = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            w_found_or = w_found_or | w_part[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_v1    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_busy <= w_accept;
            r_v1   <= r_busy;
            r_done <= r_v1;
            if (w_ctl.ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_ctl.del) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (r_req.req_type == REQ_QUERY) begin
            r_st1 <= w_found ? ST_MATCH : ST_NOFIT;
        end else begin
            r_st1 <= w_full ? ST_FULL : ST_INSERTED;
        end
        r_result.status      <= r_st1;
        r_result.found_value <= w_found_or;
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    `MFE_ASSERT(a_count_range, r_count <= CNT_W'(CAPACITY), "fill count above capacity")
    `MFE_ASSERT_NEXT(a_busy_one, w_accept, r_busy && !w_accept, "update cycle missing")
    `MFE_ASSERT(a_accept_done, w_accept |-> ##3 o_done, "transaction produced no result")
    `MFE_ASSERT_NEXT(a_full_hold, r_busy && w_full && (r_req.req_type == REQ_INSERT),
        r_count == CNT_W'(CAPACITY), "insert into full store changed the count")

endmodule

[src/mfe_cell.sv]
`timescale 1ns / 1ps

module mfe_cell
    import mfe_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  t_amount   i_amount,
    input  t_amount   i_load,
    input  t_amount   i_lo_value,
    input  logic      i_lo_le,
    input  t_amount   i_hi_value,
    input  logic      i_hi_le,
    output t_amount   o_value,
    output logic      o_le,
    output t_amount   o_pick
);

    t_amount r_value;
    t_amount n_value;
    logic    r_le;
    logic    n_le;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins && !r_le) begin
            // first cell above the insert point takes the new value, the rest shift up
            n_value = i_lo_le ? i_load : i_lo_value;
        end else if (i_ctl.del && !i_hi_le) begin
            n_value = i_hi_value;
        end
    end

    always_comb begin
        n_le = r_le;
        if (i_ctl.cmp) begin
            n_le = i_valid && (r_value <= i_amount);
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_le    <= n_le;
    end

    assign o_value = r_value;
    assign o_le    = r_le;
    // the last cell at or below the limit is the match
    assign o_pick  = (i_ctl.pick && r_le && !i_hi_le) ? r_value : '0;

endmodule

[src/mfe_group.sv]
`timescale 1ns / 1ps

module mfe_group
    import mfe_pkg::*;
(
    input  logic                          i_clk,
    input  logic [GRP_SIZE-1:0][AMT_W-1:0] i_picks,
    output t_amount                       o_any
);

    t_amount r_any;
    t_amount n_any;

    always_comb begin
        n_any = '0;
        for (int k = 0; k < GRP_SIZE; k++) begin
            n_any = n_any | i_picks[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_any <= n_any;
    end

    assign o_any = r_any;

endmodule
